/* hw/rtl/bfc_pkg.sv */
`timescale 1ns / 1ps

package bfc_pkg;

    // Default sizing of the queue.
    localparam int BFC_QUEUE_DEPTH = 16;
    localparam int BFC_DATA_WIDTH  = 32;

    // Width of the event counters reported with every result.
    localparam int BFC_STAT_W = 64;

    // Operation codes carried by a request transaction.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLOSE = 2'd2
    } t_opcode;

    // Status codes carried by a response transaction.
    typedef enum logic [2:0] {
        ST_ENQUEUED   = 3'd0,
        ST_FULL       = 3'd1,
        ST_CLOSED_REJ = 3'd2,
        ST_POPPED     = 3'd3,
        ST_EMPTY      = 3'd4,
        ST_CLOSED     = 3'd5
    } t_status;

    // Per-cell control: load the pushed word, or take the neighbor's word.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

/* hw/rtl/bfc_req_if.sv */
`timescale 1ns / 1ps

interface bfc_req_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [DATA_WIDTH-1:0] push_data;

    modport source (output valid, output opcode, output push_data, input ready);
    modport sink   (input valid, input opcode, input push_data, output ready);
endinterface

/* hw/rtl/bfc_rsp_if.sv */
`timescale 1ns / 1ps

interface bfc_rsp_if #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_WIDTH  = 5,
    parameter int STAT_WIDTH = 64
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            op_status;
    logic [DATA_WIDTH-1:0] pop_data;
    logic [CNT_WIDTH-1:0]  occupancy;
    logic                  drained;
    logic [STAT_WIDTH-1:0] enqueued_total;
    logic [STAT_WIDTH-1:0] dequeued_total;
    logic [STAT_WIDTH-1:0] full_reject_total;
    logic [STAT_WIDTH-1:0] closed_reject_total;

    modport source (
        output valid, output op_status, output pop_data, output occupancy,
        output drained, output enqueued_total, output dequeued_total,
        output full_reject_total, output closed_reject_total, input ready
    );
    modport sink (
        input valid, input op_status, input pop_data, input occupancy,
        input drained, input enqueued_total, input dequeued_total,
        input full_reject_total, input closed_reject_total, output ready
    );
endinterface

/* hw/rtl/bfc_cell.sv */
`timescale 1ns / 1ps

module bfc_cell
    import bfc_pkg::*;
#(
    parameter int DATA_WIDTH = BFC_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;

    // A push lands in the first free cell; a pop moves every word one cell
    // toward the head.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_push_data;
        end else if (i_ctl.shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

/* hw/rtl/bfc_stat_cnt.sv */
`timescale 1ns / 1ps

module bfc_stat_cnt
    import bfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_inc,
    output logic [BFC_STAT_W-1:0] o_count
);

    logic [BFC_STAT_W-1:0] r_count;
    logic [BFC_STAT_W-1:0] n_count;

    // Saturating increment: the counter sticks at all ones.
    always_comb begin
        n_count = r_count;
        if (i_inc && !(&r_count)) begin
            n_count = r_count + BFC_STAT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

/* hw/rtl/bounded_fifo_with_close_and_stats.sv */
`timescale 1ns / 1ps

// Channel   Direction  Role    Handshake     Payload
// i_req     in         sink    valid/ready   opcode, push_data
// o_rsp     out        source  valid/ready   op_status, pop_data, occupancy, drained,
//                                            four saturating event totals
//
// One request transaction is taken per cycle while i_req.ready is high; its response
// is registered and shows on o_rsp in the next cycle. Entries live in a row of cells
// that shift toward the head on a pop.
// i_req.ready is low only while a response waits and o_rsp.ready is low.
// Synchronous active-low reset empties and opens the queue and clears the totals;
// no clearing pass is needed.

module bounded_fifo_with_close_and_stats
    import bfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = BFC_QUEUE_DEPTH,
    parameter int DATA_WIDTH  = BFC_DATA_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfc_req_if.sink    i_req,
    bfc_rsp_if.source  o_rsp
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    // Queue control state.
    logic [CntW-1:0]       r_count;
    logic [CntW-1:0]       n_count;
    logic                  r_closed;
    logic                  n_closed;

    // Response register.
    logic                  r_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [DATA_WIDTH-1:0] r_pop_data;
    logic [DATA_WIDTH-1:0] n_pop_data;
    logic [CntW-1:0]       r_occ;
    logic                  r_drained;

    logic                  req_fire;
    t_opcode               op;
    logic                  push_ok;
    logic                  pop_ok;
    logic                  full_rej;
    logic                  closed_rej;
    logic [QUEUE_DEPTH-1:0] load_vec;

    logic [DATA_WIDTH-1:0] cell_data [QUEUE_DEPTH];

    // Accept a request whenever the response register is free or draining.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_fire    = i_req.valid && i_req.ready;
    assign op          = t_opcode'(i_req.opcode);

    // Decode the operation against the current queue state.
    always_comb begin
        push_ok    = 1'b0;
        pop_ok     = 1'b0;
        full_rej   = 1'b0;
        closed_rej = 1'b0;
        n_closed   = r_closed;
        n_status   = ST_CLOSED;
        if (req_fire) begin
            unique case (op)
                OP_PUSH: begin
                    priority if (r_closed) begin
                        closed_rej = 1'b1;
                        n_status   = ST_CLOSED_REJ;
                    end else if (r_count == CntW'(QUEUE_DEPTH)) begin
                        full_rej = 1'b1;
                        n_status = ST_FULL;
                    end else begin
                        push_ok  = 1'b1;
                        n_status = ST_ENQUEUED;
                    end
                end
                OP_POP: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        pop_ok   = 1'b1;
                        n_status = ST_POPPED;
                    end
                end
                default: begin
                    // Close admission; the unused code behaves the same.
                    n_closed = 1'b1;
                    n_status = ST_CLOSED;
                end
            endcase
        end
    end

    // Occupancy update and popped word.
    always_comb begin
        n_count    = r_count;
        n_pop_data = '0;
        if (push_ok) begin
            n_count = r_count + CntW'(1);
        end else if (pop_ok) begin
            n_count    = r_count - CntW'(1);
            n_pop_data = cell_data[0];
        end
    end

    // Row of storage cells; cell zero always holds the oldest entry.
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_cell_ctl             ctl;
        logic [DATA_WIDTH-1:0] next_data;

        assign load_vec[k] = push_ok && (r_count == CntW'(k));
        assign ctl.load    = load_vec[k];
        assign ctl.shift   = pop_ok;

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign next_data = '0;
        end else begin : g_body
            assign next_data = cell_data[k+1];
        end

        bfc_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_push_data (i_req.push_data),
            .i_next_data (next_data),
            .o_data      (cell_data[k])
        );
    end

    // Event totals, reported as they stand after the last transaction.
    bfc_stat_cnt u_enq_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(push_ok),
        .o_count(o_rsp.enqueued_total)
    );
    bfc_stat_cnt u_deq_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(pop_ok),
        .o_count(o_rsp.dequeued_total)
    );
    bfc_stat_cnt u_full_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(full_rej),
        .o_count(o_rsp.full_reject_total)
    );
    bfc_stat_cnt u_closed_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(closed_rej),
        .o_count(o_rsp.closed_reject_total)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_closed <= n_closed;
            if (req_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload, loaded with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_status   <= n_status;
            r_pop_data <= n_pop_data;
            r_occ      <= n_count;
            r_drained  <= n_closed && (n_count == '0);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.op_status = r_status;
    assign o_rsp.pop_data  = r_pop_data;
    assign o_rsp.occupancy = r_occ;
    assign o_rsp.drained   = r_drained;

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // Once closed, the queue stays closed until reset.
    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("closed flag cleared without reset");

    // At most one cell takes a pushed word.
    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(load_vec))
        else $error("more than one cell loaded");

    // A successful pop removes exactly one entry.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_ok |=> r_count == $past(r_count) - CntW'(1))
        else $error("pop did not decrement occupancy");

    // A drained response reports an empty queue.
    a_drained_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_drained) |-> (r_occ == '0))
        else $error("drained reported with entries held");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
    import bfc_pkg::*;
;

    localparam int QD          = BFC_QUEUE_DEPTH;
    localparam int DW          = BFC_DATA_WIDTH;
    localparam int OCC_W       = $clog2(QD + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_SLACK = 4;
    localparam int OPEN_ITEMS  = 720;
    localparam int SHUT_ITEMS  = 55;
    localparam int MAX_REPORTS = 10;

    // The spare opcode, which the block treats as a close.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // One response transaction as the queue reports it.
    typedef struct packed {
        t_status              status;
        logic [DW-1:0]        pop_data;
        logic [OCC_W-1:0]     occupancy;
        logic                 drained;
        logic [BFC_STAT_W-1:0] enq_total;
        logic [BFC_STAT_W-1:0] deq_total;
        logic [BFC_STAT_W-1:0] full_total;
        logic [BFC_STAT_W-1:0] closed_total;
    } t_fifo_rsp;

    // One row of the directed table; the typed fields hold only when known is set.
    typedef struct {
        logic [1:0]       op;
        logic [DW-1:0]    data;
        int               reps;
        bit               known;
        t_status          status;
        logic [DW-1:0]    pop_data;
        logic [OCC_W-1:0] occupancy;
        logic             drained;
    } t_stim_row;

    localparam int NUM_ROWS  = 21;
    localparam int OPEN_LAST = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bfc_req_if #(.DATA_WIDTH(DW)) req_if ();
    bfc_rsp_if #(.DATA_WIDTH(DW), .CNT_WIDTH(OCC_W), .STAT_WIDTH(BFC_STAT_W)) rsp_if ();

    bounded_fifo_with_close_and_stats #(
        .QUEUE_DEPTH(QD),
        .DATA_WIDTH (DW)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the queue state.
    logic [DW-1:0]         shadow_slots [QD];
    int                    shadow_wr;
    int                    shadow_rd;
    int                    shadow_count;
    logic                  shadow_closed;
    logic [BFC_STAT_W-1:0] shadow_enq;
    logic [BFC_STAT_W-1:0] shadow_deq;
    logic [BFC_STAT_W-1:0] shadow_full;
    logic [BFC_STAT_W-1:0] shadow_shut;

    t_fifo_rsp expected_rsp_q [$];
    t_stim_row stim_tab [NUM_ROWS];

    int  error_count = 0;
    int  cycle_count = 0;
    int  burst_left  = 0;

    t_fifo_rsp seen_rsp;
    t_fifo_rsp want_rsp;

    // Free-running clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [BFC_STAT_W-1:0] bump_sat(input logic [BFC_STAT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic int ring_next(input int p);
        return (p == QD - 1) ? 0 : p + 1;
    endfunction

    // Apply one operation to the shadow queue and return the response it yields.
    function automatic t_fifo_rsp fifo_apply(input logic [1:0] op, input logic [DW-1:0] data);
        t_fifo_rsp r;
        r = '0;
        if (op == OP_PUSH) begin
            if (shadow_closed) begin
                shadow_shut = bump_sat(shadow_shut);
                r.status = ST_CLOSED_REJ;
            end else if (shadow_count >= QD) begin
                shadow_full = bump_sat(shadow_full);
                r.status = ST_FULL;
            end else begin
                shadow_slots[shadow_wr] = data;
                shadow_wr = ring_next(shadow_wr);
                shadow_count++;
                shadow_enq = bump_sat(shadow_enq);
                r.status = ST_ENQUEUED;
            end
        end else if (op == OP_POP) begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.pop_data = shadow_slots[shadow_rd];
                shadow_rd = ring_next(shadow_rd);
                shadow_count--;
                shadow_deq = bump_sat(shadow_deq);
                r.status = ST_POPPED;
            end
        end else begin
            shadow_closed = 1'b1;
            r.status = ST_CLOSED;
        end
        r.occupancy    = shadow_count[OCC_W-1:0];
        r.drained      = shadow_closed && (shadow_count == 0);
        r.enq_total    = shadow_enq;
        r.deq_total    = shadow_deq;
        r.full_total   = shadow_full;
        r.closed_total = shadow_shut;
        return r;
    endfunction

    function automatic logic [DW-1:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Offer one request transaction, honoring the burst/gap pattern, and
    // record its expected response once it is accepted.
    task automatic send_op(input logic [1:0] op, input logic [DW-1:0] data,
                           input bit known, input t_fifo_rsp typed);
        int gap;
        t_fifo_rsp r;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.opcode    <= op;
        req_if.push_data <= data;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        r = fifo_apply(op, data);
        if (known) begin
            r.status    = typed.status;
            r.pop_data  = typed.pop_data;
            r.occupancy = typed.occupancy;
            r.drained   = typed.drained;
        end
        expected_rsp_q.push_back(r);
        burst_left--;
    endtask

    // Hold off new requests until every response is back.
    task automatic hold_until_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic walk_table(input int first, input int last);
        t_fifo_rsp typed;
        for (int r = first; r <= last; r++) begin
            for (int k = 0; k < stim_tab[r].reps; k++) begin
                typed           = '0;
                typed.status    = stim_tab[r].status;
                typed.pop_data  = stim_tab[r].pop_data;
                typed.occupancy = stim_tab[r].occupancy;
                typed.drained   = stim_tab[r].drained;
                send_op(stim_tab[r].op, stim_tab[r].data + DW'(k), stim_tab[r].known, typed);
            end
        end
    endtask

    // Receiver back-pressure: switches among always ready, coin flips, rare
    // ready and long alternating runs.
    int   sink_mode = 0;
    int   sink_mode_left = 0;
    int   sink_run_left = 0;
    logic sink_level = 1'b1;

    always @(negedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode      = $urandom_range(0, 3);
            sink_mode_left = $urandom_range(20, 200);
        end else begin
            sink_mode_left--;
        end
        case (sink_mode)
            0: begin
                rsp_if.ready <= 1'b1;
            end
            1: begin
                rsp_if.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                rsp_if.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (sink_run_left == 0) begin
                    sink_level    = ~sink_level;
                    sink_run_left = $urandom_range(1, 12);
                end
                sink_run_left--;
                rsp_if.ready <= sink_level;
            end
        endcase
    end

    // Response checker.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            seen_rsp.status       = t_status'(rsp_if.op_status);
            seen_rsp.pop_data     = rsp_if.pop_data;
            seen_rsp.occupancy    = rsp_if.occupancy;
            seen_rsp.drained      = rsp_if.drained;
            seen_rsp.enq_total    = rsp_if.enqueued_total;
            seen_rsp.deq_total    = rsp_if.dequeued_total;
            seen_rsp.full_total   = rsp_if.full_reject_total;
            seen_rsp.closed_total = rsp_if.closed_reject_total;
            if (expected_rsp_q.size() == 0) begin
                note_failure($sformatf("response with none pending: status=%0d data=%h",
                                       seen_rsp.status, seen_rsp.pop_data));
            end else begin
                want_rsp = expected_rsp_q.pop_front();
                if (seen_rsp !== want_rsp) begin
                    note_failure($sformatf(
                        {"response mismatch\n  exp: st=%0d data=%h occ=%0d drn=%b",
                         " enq=%0d deq=%0d full=%0d shut=%0d\n  got: st=%0d data=%h",
                         " occ=%0d drn=%b enq=%0d deq=%0d full=%0d shut=%0d"},
                        want_rsp.status, want_rsp.pop_data, want_rsp.occupancy,
                        want_rsp.drained, want_rsp.enq_total, want_rsp.deq_total,
                        want_rsp.full_total, want_rsp.closed_total,
                        seen_rsp.status, seen_rsp.pop_data, seen_rsp.occupancy,
                        seen_rsp.drained, seen_rsp.enq_total, seen_rsp.deq_total,
                        seen_rsp.full_total, seen_rsp.closed_total));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] ERROR: timeout with %0d responses pending",
                     $realtime, expected_rsp_q.size());
            $display("** bounded_fifo_with_close_and_stats: FAILED **");
            $finish;
        end
    end

    // Main stimulus.
    initial begin
        int         sent;
        int         seg_len;
        int         push_pct;
        logic [1:0] op;

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.opcode    = OP_PUSH;
        req_if.push_data = '0;

        for (int i = 0; i < QD; i++) shadow_slots[i] = '0;
        shadow_wr     = 0;
        shadow_rd     = 0;
        shadow_count  = 0;
        shadow_closed = 1'b0;
        shadow_enq    = '0;
        shadow_deq    = '0;
        shadow_full   = '0;
        shadow_shut   = '0;

        // Directed rows: open-queue cases first, then the close sequence.
        stim_tab = '{
            '{OP_POP,   32'h0000_0000,  1, 1'b1, ST_EMPTY,      32'h0000_0000,  0, 1'b0},
            '{OP_PUSH,  32'h0000_0000,  1, 1'b1, ST_ENQUEUED,   32'h0000_0000,  1, 1'b0},
            '{OP_PUSH,  32'hFFFF_FFFF,  1, 1'b1, ST_ENQUEUED,   32'h0000_0000,  2, 1'b0},
            '{OP_POP,   32'h0000_0000,  1, 1'b1, ST_POPPED,     32'h0000_0000,  1, 1'b0},
            '{OP_POP,   32'hFFFF_FFFF,  1, 1'b1, ST_POPPED,     32'hFFFF_FFFF,  0, 1'b0},
            '{OP_POP,   32'h0000_0000,  1, 1'b1, ST_EMPTY,      32'h0000_0000,  0, 1'b0},
            '{OP_PUSH,  32'hA5A5_0000, 16, 1'b0, ST_ENQUEUED,   32'h0000_0000,  0, 1'b0},
            '{OP_PUSH,  32'h5A5A_5A5A,  1, 1'b1, ST_FULL,       32'h0000_0000, 16, 1'b0},
            '{OP_POP,   32'h0000_0000,  5, 1'b0, ST_POPPED,     32'h0000_0000,  0, 1'b0},
            '{OP_PUSH,  32'h0F0F_0000,  5, 1'b0, ST_ENQUEUED,   32'h0000_0000,  0, 1'b0},
            '{OP_PUSH,  32'hF0F0_F0F0,  1, 1'b1, ST_FULL,       32'h0000_0000, 16, 1'b0},
            '{OP_PUSH,  32'hC3C3_0000, 16, 1'b0, ST_ENQUEUED,   32'h0000_0000,  0, 1'b0},
            '{OP_PUSH,  32'h3C3C_3C3C,  1, 1'b1, ST_FULL,       32'h0000_0000, 16, 1'b0},
            '{OP_CLOSE, 32'h0000_0000,  1, 1'b1, ST_CLOSED,     32'h0000_0000, 16, 1'b0},
            '{OP_PUSH,  32'h1234_5678,  1, 1'b1, ST_CLOSED_REJ, 32'h0000_0000, 16, 1'b0},
            '{OP_CLOSE, 32'hFFFF_FFFF,  1, 1'b1, ST_CLOSED,     32'h0000_0000, 16, 1'b0},
            '{OP_SPARE, 32'h0000_0000,  1, 1'b1, ST_CLOSED,     32'h0000_0000, 16, 1'b0},
            '{OP_POP,   32'h0000_0000, 16, 1'b0, ST_POPPED,     32'h0000_0000,  0, 1'b0},
            '{OP_POP,   32'h0000_0000,  1, 1'b1, ST_EMPTY,      32'h0000_0000,  0, 1'b1},
            '{OP_PUSH,  32'h8765_4321,  1, 1'b1, ST_CLOSED_REJ, 32'h0000_0000,  0, 1'b1},
            '{OP_SPARE, 32'hFFFF_FFFF,  1, 1'b1, ST_CLOSED,     32'h0000_0000,  0, 1'b1}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        walk_table(0, OPEN_LAST);
        hold_until_drained();

        // Random traffic on the open queue; the push share shifts from
        // segment to segment so that the queue swings between empty and full.
        sent = 0;
        while (sent < OPEN_ITEMS) begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            for (int k = 0; k < seg_len; k++) begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                send_op(op, pick_data(), 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 7) == 0) hold_until_drained();
        end
        hold_until_drained();

        // Close the queue, drain it, then keep hitting it with every opcode.
        walk_table(OPEN_LAST + 1, NUM_ROWS - 1);
        for (int k = 0; k < SHUT_ITEMS; k++) begin
            send_op(2'($urandom_range(0, 3)), DW'($urandom), 1'b0, '0);
        end

        hold_until_drained();
        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (expected_rsp_q.size() != 0) begin
            note_failure($sformatf("%0d responses never arrived", expected_rsp_q.size()));
        end
        if (error_count == 0) begin
            $display("** bounded_fifo_with_close_and_stats: PASSED **");
        end else begin
            $display("** bounded_fifo_with_close_and_stats: FAILED **");
        end
        $finish;
    end

endmodule
